>>> design/lli_pkg.sv
// ----------------------------------------------------------------------------
// lli_pkg
// Shared widths, status codes and transaction types for the line-line
// intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lli_pkg;

   // coordinate width, signed fixed point; the binary point cancels in the
   // quotient so the fraction width never shows up in the datapath
   localparam int CW = 32;
   // magnitude of den = cross(d1, d2)
   localparam int DW = 2 * CW;
   // magnitude of num = cross(d1, p1 - p2)
   localparam int NW = 2 * CW + 1;
   // magnitude of num * d2
   localparam int PW = NW + CW;
   // quotient bits kept when no overflow is flagged
   localparam int QW = CW + 1;

   typedef enum logic [2:0] {
      ST_MET      = 3'd0,
      ST_DISJOINT = 3'd1,
      ST_SAME     = 3'd2,
      ST_ZERO_DIR = 3'd3,
      ST_SAT      = 3'd4
   } status_type;

   typedef struct packed {
      logic signed [CW-1:0] first_point_re;
      logic signed [CW-1:0] first_point_im;
      logic signed [CW-1:0] first_dir_re;
      logic signed [CW-1:0] first_dir_im;
      logic signed [CW-1:0] second_point_re;
      logic signed [CW-1:0] second_point_im;
      logic signed [CW-1:0] second_dir_re;
      logic signed [CW-1:0] second_dir_im;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic signed [CW-1:0] meet_re;
      logic signed [CW-1:0] meet_im;
   } rsp_type;

   // one coordinate lane inside the divider
   typedef struct packed {
      logic                 neg;
      logic                 ovf;
      logic [PW-1:0]        rem;
      logic [QW-1:0]        quo;
      logic signed [CW-1:0] base;
   } lane_type;

   typedef struct packed {
      status_type    status;
      logic [DW-1:0] den;
      lane_type      x;
      lane_type      y;
   } div_type;

   // one coordinate lane after rounding
   typedef struct packed {
      logic                 neg;
      logic                 ovf;
      logic [QW:0]          mag;
      logic signed [CW-1:0] base;
   } rlane_type;

   typedef struct packed {
      status_type status;
      rlane_type  x;
      rlane_type  y;
   } res_type;

endpackage

`default_nettype wire

>>> design/line_line_intersection.sv
// ----------------------------------------------------------------------------
// line_line_intersection
// Meeting point of two planar lines given as point and direction.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready/req_data carry one line pair per transaction: a
//   point and a direction for each line, signed Q16.16. rsp_valid/rsp_ready/
//   rsp_data return one transaction per pair: a status code and the meeting
//   point, zero unless the lines met or the point saturated.
//   The path from acceptance to rsp_valid runs through 43 register stages:
//   7 front stages (cross products, num*d2 partial products), 34 divider
//   stages (one quotient bit per stage plus rounding) and 2 output stages.
//   Throughput is one transaction per cycle while rsp_ready is high; every
//   stage has its own valid bit, and req_ready is high whenever any stage holds a bubble.
//   When the receiver stalls, results wait in the output register and
//   the pipeline keeps filling its bubbles; once full, req_ready drops.
//   Reset (synchronous, active high) empties the pipeline; no transaction
//   is lost or duplicated across a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module line_line_intersection import lli_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    f_valid, f_ready;
   div_type f_data;
   logic    d_valid, d_ready;
   res_type d_data;

   // cross products and products
   lli_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_data  (f_data)
   );

   // pipelined divide and round
   lli_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_data  (d_data)
   );

   // offset, saturate, output register
   lli_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_ready  (d_ready),
      .in_data   (d_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> design/lli_front.sv
// ----------------------------------------------------------------------------
// lli_front
// Cross products, classification, magnitudes and the num * d2 products,
// seven register stages with per-stage valid and bubble collapsing.
// ----------------------------------------------------------------------------
`default_nettype none

module lli_front import lli_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire req_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output div_type      out_data
);

   localparam int NS = 7;
   localparam int HL = (NW + 1) / 2;
   localparam int HW = NW - HL;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] rdy;

   // stage ready chain
   always_comb begin
      rdy[NS-1] = !v_ff[NS-1] || out_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NS-1];

   // stage 1: point differences and zero direction check
   logic                 s1_zero_ff;
   logic signed [CW:0]   s1_dpx_ff, s1_dpy_ff;
   logic signed [CW-1:0] s1_d1x_ff, s1_d1y_ff, s1_d2x_ff, s1_d2y_ff, s1_p2x_ff, s1_p2y_ff;

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s1_zero_ff <= (in_data.first_dir_re == '0 && in_data.first_dir_im == '0) ||
                       (in_data.second_dir_re == '0 && in_data.second_dir_im == '0);
         s1_dpx_ff  <= $signed({in_data.first_point_re[CW-1], in_data.first_point_re}) -
                       $signed({in_data.second_point_re[CW-1], in_data.second_point_re});
         s1_dpy_ff  <= $signed({in_data.first_point_im[CW-1], in_data.first_point_im}) -
                       $signed({in_data.second_point_im[CW-1], in_data.second_point_im});
         s1_d1x_ff  <= in_data.first_dir_re;
         s1_d1y_ff  <= in_data.first_dir_im;
         s1_d2x_ff  <= in_data.second_dir_re;
         s1_d2y_ff  <= in_data.second_dir_im;
         s1_p2x_ff  <= in_data.second_point_re;
         s1_p2y_ff  <= in_data.second_point_im;
      end
   end

   // stage 2: the four cross product terms
   logic                   s2_zero_ff;
   logic signed [2*CW-1:0] s2_dd1_ff, s2_dd2_ff;
   logic signed [2*CW:0]   s2_np1_ff, s2_np2_ff;
   logic signed [CW-1:0]   s2_d2x_ff, s2_d2y_ff, s2_p2x_ff, s2_p2y_ff;

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s2_zero_ff <= s1_zero_ff;
         s2_dd1_ff  <= s1_d1x_ff * s1_d2y_ff;
         s2_dd2_ff  <= s1_d1y_ff * s1_d2x_ff;
         s2_np1_ff  <= s1_d1x_ff * s1_dpy_ff;
         s2_np2_ff  <= s1_d1y_ff * s1_dpx_ff;
         s2_d2x_ff  <= s1_d2x_ff;
         s2_d2y_ff  <= s1_d2y_ff;
         s2_p2x_ff  <= s1_p2x_ff;
         s2_p2y_ff  <= s1_p2y_ff;
      end
   end

   // stage 3: den and num
   logic                   s3_zero_ff;
   logic signed [2*CW:0]   s3_den_ff;
   logic signed [2*CW+1:0] s3_num_ff;
   logic signed [CW-1:0]   s3_d2x_ff, s3_d2y_ff, s3_p2x_ff, s3_p2y_ff;

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         s3_zero_ff <= s2_zero_ff;
         s3_den_ff  <= s2_dd1_ff - s2_dd2_ff;
         s3_num_ff  <= s2_np1_ff - s2_np2_ff;
         s3_d2x_ff  <= s2_d2x_ff;
         s3_d2y_ff  <= s2_d2y_ff;
         s3_p2x_ff  <= s2_p2x_ff;
         s3_p2y_ff  <= s2_p2y_ff;
      end
   end

   // stage 4: classify and take magnitudes
   logic signed [2*CW:0]   den_abs;
   logic signed [2*CW+1:0] num_abs;
   logic signed [CW-1:0]   d2x_abs, d2y_abs;
   status_type             s4_status_in;

   always_comb begin
      den_abs = s3_den_ff[2*CW] ? -s3_den_ff : s3_den_ff;
      num_abs = s3_num_ff[2*CW+1] ? -s3_num_ff : s3_num_ff;
      d2x_abs = s3_d2x_ff[CW-1] ? -s3_d2x_ff : s3_d2x_ff;
      d2y_abs = s3_d2y_ff[CW-1] ? -s3_d2y_ff : s3_d2y_ff;
      if (s3_zero_ff) begin
         s4_status_in = ST_ZERO_DIR;
      end else if (s3_den_ff == '0) begin
         s4_status_in = (s3_num_ff == '0) ? ST_SAME : ST_DISJOINT;
      end else begin
         s4_status_in = ST_MET;
      end
   end

   status_type           s4_status_ff;
   logic                 s4_negx_ff, s4_negy_ff;
   logic [DW-1:0]        s4_den_ff;
   logic [NW-1:0]        s4_num_ff;
   logic [CW-1:0]        s4_d2x_ff, s4_d2y_ff;
   logic signed [CW-1:0] s4_p2x_ff, s4_p2y_ff;

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         s4_status_ff <= s4_status_in;
         s4_negx_ff   <= s3_den_ff[2*CW] ^ s3_num_ff[2*CW+1] ^ s3_d2x_ff[CW-1];
         s4_negy_ff   <= s3_den_ff[2*CW] ^ s3_num_ff[2*CW+1] ^ s3_d2y_ff[CW-1];
         s4_den_ff    <= den_abs[DW-1:0];
         s4_num_ff    <= num_abs[NW-1:0];
         s4_d2x_ff    <= d2x_abs;
         s4_d2y_ff    <= d2y_abs;
         s4_p2x_ff    <= s3_p2x_ff;
         s4_p2y_ff    <= s3_p2y_ff;
      end
   end

   // stage 5: num * d2 as low and high partial products
   status_type           s5_status_ff;
   logic                 s5_negx_ff, s5_negy_ff;
   logic [DW-1:0]        s5_den_ff;
   logic [HL+CW-1:0]     s5_xl_ff, s5_yl_ff;
   logic [HW+CW-1:0]     s5_xh_ff, s5_yh_ff;
   logic signed [CW-1:0] s5_p2x_ff, s5_p2y_ff;

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         s5_status_ff <= s4_status_ff;
         s5_negx_ff   <= s4_negx_ff;
         s5_negy_ff   <= s4_negy_ff;
         s5_den_ff    <= s4_den_ff;
         s5_xl_ff     <= s4_num_ff[HL-1:0] * s4_d2x_ff;
         s5_xh_ff     <= s4_num_ff[NW-1:HL] * s4_d2x_ff;
         s5_yl_ff     <= s4_num_ff[HL-1:0] * s4_d2y_ff;
         s5_yh_ff     <= s4_num_ff[NW-1:HL] * s4_d2y_ff;
         s5_p2x_ff    <= s4_p2x_ff;
         s5_p2y_ff    <= s4_p2y_ff;
      end
   end

   // stage 6: combine partial products
   status_type           s6_status_ff;
   logic                 s6_negx_ff, s6_negy_ff;
   logic [DW-1:0]        s6_den_ff;
   logic [PW-1:0]        s6_px_ff, s6_py_ff;
   logic signed [CW-1:0] s6_p2x_ff, s6_p2y_ff;

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         s6_status_ff <= s5_status_ff;
         s6_negx_ff   <= s5_negx_ff;
         s6_negy_ff   <= s5_negy_ff;
         s6_den_ff    <= s5_den_ff;
         s6_px_ff     <= PW'(s5_xl_ff) + (PW'(s5_xh_ff) << HL);
         s6_py_ff     <= PW'(s5_yl_ff) + (PW'(s5_yh_ff) << HL);
         s6_p2x_ff    <= s5_p2x_ff;
         s6_p2y_ff    <= s5_p2y_ff;
      end
   end

   // stage 7: quotient overflow check, quotient would reach 2^(CW+1)
   logic [PW-1:0] den_top;
   div_type       s7_in;
   div_type       s7_ff;

   always_comb begin
      den_top       = PW'(s6_den_ff) << (CW + 1);
      s7_in.status  = s6_status_ff;
      s7_in.den     = s6_den_ff;
      s7_in.x.neg   = s6_negx_ff;
      s7_in.x.ovf   = s6_px_ff >= den_top;
      s7_in.x.rem   = s6_px_ff;
      s7_in.x.quo   = '0;
      s7_in.x.base  = s6_p2x_ff;
      s7_in.y.neg   = s6_negy_ff;
      s7_in.y.ovf   = s6_py_ff >= den_top;
      s7_in.y.rem   = s6_py_ff;
      s7_in.y.quo   = '0;
      s7_in.y.base  = s6_p2y_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         s7_ff <= s7_in;
      end
   end

   assign out_data = s7_ff;

endmodule

`default_nettype wire

>>> design/lli_div.sv
// ----------------------------------------------------------------------------
// lli_div
// Pipelined restoring divider, one quotient bit per stage for both
// coordinates, then a round-half-away stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lli_div import lli_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire div_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output res_type      out_data
);

   localparam int NS = QW + 1;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] rdy;

   // stage ready chain
   always_comb begin
      rdy[NS-1] = !v_ff[NS-1] || out_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NS-1];

   // one quotient bit: subtract den shifted to that bit if it fits
   function automatic lane_type div_step(lane_type l, logic [DW-1:0] d, int b);
      logic [PW-1:0] t;
      lane_type      r;
      r = l;
      t = PW'(d) << b;
      if (l.rem >= t) begin
         r.rem = l.rem - t;
         r.quo = l.quo | (QW'(1) << b);
      end
      return r;
   endfunction

   div_type step_ff [QW];
   div_type step_in [QW];

   // stage k resolves quotient bit QW-1-k
   always_comb begin
      for (int k = 0; k < QW; k++) begin
         step_in[k] = (k == 0) ? in_data : step_ff[(k == 0) ? 0 : k - 1];
         step_in[k].x = div_step(step_in[k].x, step_in[k].den, QW - 1 - k);
         step_in[k].y = div_step(step_in[k].y, step_in[k].den, QW - 1 - k);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QW; k++) begin
         if (rdy[k]) begin
            step_ff[k] <= step_in[k];
         end
      end
   end

   // rounding: round up when twice the remainder reaches den
   div_type last;
   res_type rnd_in;
   res_type rnd_ff;
   logic    up_x, up_y;

   always_comb begin
      last           = step_ff[QW-1];
      up_x           = {last.x.rem[DW-1:0], 1'b0} >= {1'b0, last.den};
      up_y           = {last.y.rem[DW-1:0], 1'b0} >= {1'b0, last.den};
      rnd_in.status  = last.status;
      rnd_in.x.neg   = last.x.neg;
      rnd_in.x.ovf   = last.x.ovf;
      rnd_in.x.mag   = {1'b0, last.x.quo} + (QW+1)'(up_x);
      rnd_in.x.base  = last.x.base;
      rnd_in.y.neg   = last.y.neg;
      rnd_in.y.ovf   = last.y.ovf;
      rnd_in.y.mag   = {1'b0, last.y.quo} + (QW+1)'(up_y);
      rnd_in.y.base  = last.y.base;
   end

   always_ff @(posedge clock) begin
      if (rdy[NS-1]) begin
         rnd_ff <= rnd_in;
      end
   end

   assign out_data = rnd_ff;

endmodule

`default_nettype wire

>>> design/lli_out.sv
// ----------------------------------------------------------------------------
// lli_out
// Adds the second line's point to the signed quotient, saturates to the
// coordinate range and holds the result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module lli_out import lli_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire res_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_data
);

   logic [1:0] v_ff;
   logic [1:0] rdy;

   assign rdy[1]    = !v_ff[1] || out_ready;
   assign rdy[0]    = !v_ff[0] || rdy[1];
   assign in_ready  = rdy[0];
   assign out_valid = v_ff[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         if (rdy[1]) begin
            v_ff[1] <= v_ff[0];
         end
      end
   end

   // stage 1: signed quotient plus point
   logic signed [CW+2:0] mx, my;
   logic signed [CW+2:0] sx_ff, sy_ff;
   logic                 ovfx_ff, ovfy_ff, negx_ff, negy_ff;
   status_type           status_ff;

   always_comb begin
      mx = $signed({1'b0, in_data.x.mag});
      my = $signed({1'b0, in_data.y.mag});
      if (in_data.x.neg) begin
         mx = -mx;
      end
      if (in_data.y.neg) begin
         my = -my;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         sx_ff     <= mx + in_data.x.base;
         sy_ff     <= my + in_data.y.base;
         ovfx_ff   <= in_data.x.ovf;
         ovfy_ff   <= in_data.y.ovf;
         negx_ff   <= in_data.x.neg;
         negy_ff   <= in_data.y.neg;
         status_ff <= in_data.status;
      end
   end

   // stage 2: saturate and pick the status
   localparam logic signed [CW+2:0] SMAX = $signed({4'b0000, {(CW-1){1'b1}}});
   localparam logic signed [CW+2:0] SMIN = $signed({4'b1111, {(CW-1){1'b0}}});
   localparam logic [CW-1:0]        VMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0]        VMIN = {1'b1, {(CW-1){1'b0}}};

   logic          satx, saty;
   logic [CW-1:0] vx, vy;
   rsp_type       rsp_in;
   rsp_type       rsp_ff;

   always_comb begin
      satx = 1'b1;
      saty = 1'b1;
      if (ovfx_ff) begin
         vx = negx_ff ? VMIN : VMAX;
      end else if (sx_ff > SMAX) begin
         vx = VMAX;
      end else if (sx_ff < SMIN) begin
         vx = VMIN;
      end else begin
         vx   = sx_ff[CW-1:0];
         satx = 1'b0;
      end
      if (ovfy_ff) begin
         vy = negy_ff ? VMIN : VMAX;
      end else if (sy_ff > SMAX) begin
         vy = VMAX;
      end else if (sy_ff < SMIN) begin
         vy = VMIN;
      end else begin
         vy   = sy_ff[CW-1:0];
         saty = 1'b0;
      end
      if (status_ff != ST_MET) begin
         rsp_in.status  = status_ff;
         rsp_in.meet_re = '0;
         rsp_in.meet_im = '0;
      end else begin
         rsp_in.status  = (satx || saty) ? ST_SAT : ST_MET;
         rsp_in.meet_re = vx;
         rsp_in.meet_im = vy;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_data = rsp_ff;

endmodule

`default_nettype wire
